@@ design/snaprec_pkg.sv @@
// ----------------------------------------------------------------------------
// snaprec_pkg
// Shared types and codes of the snapshot record deserializer.
// ----------------------------------------------------------------------------
package snaprec_pkg;

  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned ENTRY_BYTES  = 17;
  localparam int unsigned BYTE_BITS    = 8;
  localparam int unsigned ASM_BITS     = 128;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned CFG_INDEX_W  = 8;
  localparam int unsigned CFG_DATA_W   = 32;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_ENTRY  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // end status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SHORT     = 2'd1;
  localparam logic [1:0] STATUS_MALFORMED = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SCHEMA_WORD = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT_LIMIT = 8'd1;

  // one classified word: an optional header or entry result plus an optional status
  typedef struct packed {
    logic        has_data;
    logic [1:0]  data_kind;
    logic [63:0] word_a;    // tick or entity id
    logic [63:0] word_b;    // entity value
    logic [31:0] count;
    logic        alive;
    logic        has_status;
    logic [1:0]  status;
  } snaprec_evt_t;

endpackage

@@ design/snapshot_record_deserializer.sv @@
// ----------------------------------------------------------------------------
// snapshot_record_deserializer
// Parses a little-endian snapshot byte stream into header, entry and status words.
// ----------------------------------------------------------------------------
// Input channel: one byte per word (in_data_byte, in_end_of_buffer), taken when
// in_valid is high and in_stall low. Up to one byte per cycle is accepted.
// Output channel: result words (header, entry, end status) with out_run_last
// on the last word caused by a byte; taken when out_valid high, out_stall low.
// Configuration: cfg_valid/cfg_ready write channel, index 0 schema version,
// index 1 max entries; cfg_ready is always high, other indexes are ignored.
// The parser classifies each byte in the cycle it is accepted and pushes any
// word it causes into a QUEUE_DEPTH-entry queue; the first such word reaches
// the output through the queue slot and then the output register. A byte that
// causes a header or entry result plus the end status yields two result words;
// every other byte yields at most one.
// Sustained rate is one byte per cycle; in_stall rises only while the queue
// is full, which happens when the receiver stalls long enough.
// Reset clears the parser to the header phase, empties the queue and sets
// the registers to schema version 1 and max entries 65535.
// ----------------------------------------------------------------------------
module snapshot_record_deserializer #(
  parameter int unsigned QUEUE_DEPTH = snaprec_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_end_of_buffer,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [snaprec_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [snaprec_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_result_kind,
  output logic [63:0]                         out_tick,
  output logic [31:0]                         out_entry_count,
  output logic [63:0]                         out_entity_id,
  output logic signed [63:0]                  out_entry_value,
  output logic                                out_alive,
  output logic [1:0]                          out_status,
  output logic                                out_run_last
);
  import snaprec_pkg::*;

  snaprec_evt_t push_evt;
  snaprec_evt_t head_evt;
  logic         push;
  logic         pop;
  logic         full;
  logic         empty;
  logic         in_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign in_fire   = in_valid && !in_stall;

  snaprec_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (in_fire),
    .data_byte     (in_data_byte),
    .end_of_buffer (in_end_of_buffer),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .evt           (push_evt)
  );

  snaprec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .head_evt (head_evt),
    .full     (full),
    .empty    (empty)
  );

  snaprec_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_evt         (head_evt),
    .empty            (empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_tick         (out_tick),
    .out_entry_count  (out_entry_count),
    .out_entity_id    (out_entity_id),
    .out_entry_value  (out_entry_value),
    .out_alive        (out_alive),
    .out_status       (out_status),
    .out_run_last     (out_run_last)
  );

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");

  // an entry word never carries a zero entity
  a_entry_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_ENTRY) |-> (out_entity_id != 64'd0))
    else $error("entry word with zero entity");

  // the end status is always the last word of its byte
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_STATUS) |-> out_run_last)
    else $error("status word not marked last");

endmodule

@@ design/snaprec_front.sv @@
// ----------------------------------------------------------------------------
// snaprec_front
// Byte parser: assembles header and entry fields and classifies each word.
// ----------------------------------------------------------------------------
module snaprec_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                fire,
  input  logic [7:0]                          data_byte,
  input  logic                                end_of_buffer,
  input  logic                                cfg_we,
  input  logic [snaprec_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [snaprec_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                push,
  output snaprec_pkg::snaprec_evt_t           evt
);
  import snaprec_pkg::*;

  localparam logic [1:0] PH_HEADER   = 2'd0;
  localparam logic [1:0] PH_ENTRIES  = 2'd1;
  localparam logic [1:0] PH_TRAILING = 2'd2;
  localparam logic [1:0] PH_SWALLOW  = 2'd3;

  localparam logic [POS_W-1:0] HDR_LAST = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] ENT_LAST = POS_W'(ENTRY_BYTES - 1);

  logic [1:0]          phase_r, phase_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [ASM_BITS-1:0] asm_r, asm_nxt;
  logic [31:0]         left_r, left_nxt;
  logic                err_r, err_nxt;
  logic [31:0]         schema_r, schema_nxt;
  logic [31:0]         max_r, max_nxt;
  logic [ASM_BITS-1:0] hdr;

  assign hdr = {data_byte, asm_r[ASM_BITS-1:BYTE_BITS]};

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    asm_nxt   = asm_r;
    left_nxt  = left_r;
    err_nxt   = err_r;
    evt       = '0;
    case (phase_r)
      PH_HEADER: begin
        asm_nxt = hdr;
        if (pos_r < HDR_LAST) begin
          pos_nxt = pos_r + POS_W'(1);
        end else begin
          pos_nxt = '0;
          if (hdr[31:0] == schema_r && hdr[127:96] <= max_r) begin
            evt.has_data  = 1'b1;
            evt.data_kind = KIND_HEADER;
            evt.word_a    = hdr[95:32];
            evt.count     = hdr[127:96];
            left_nxt      = hdr[127:96];
            phase_nxt     = (hdr[127:96] == 32'd0) ? PH_TRAILING : PH_ENTRIES;
          end else begin
            err_nxt   = 1'b1;
            phase_nxt = PH_SWALLOW;
          end
        end
      end
      PH_ENTRIES: begin
        if (pos_r < ENT_LAST) begin
          asm_nxt = hdr;
          pos_nxt = pos_r + POS_W'(1);
        end else begin
          pos_nxt = '0;
          if (asm_r[63:0] != 64'd0 && data_byte[7:1] == 7'd0) begin
            evt.has_data  = 1'b1;
            evt.data_kind = KIND_ENTRY;
            evt.word_a    = asm_r[63:0];
            evt.word_b    = asm_r[127:64];
            evt.alive     = data_byte[0];
            left_nxt      = left_r - 32'd1;
            if (left_r == 32'd1) begin
              phase_nxt = PH_TRAILING;
            end
          end else begin
            err_nxt   = 1'b1;
            phase_nxt = PH_SWALLOW;
          end
        end
      end
      PH_TRAILING: begin
        // any byte past the announced entries is a length mismatch
        err_nxt   = 1'b1;
        phase_nxt = PH_SWALLOW;
      end
      default: begin
      end
    endcase

    if (end_of_buffer) begin
      evt.has_status = 1'b1;
      if (err_nxt) begin
        evt.status = STATUS_MALFORMED;
      end else if (phase_nxt == PH_HEADER) begin
        evt.status = STATUS_SHORT;
      end else if (phase_nxt == PH_TRAILING) begin
        evt.status = STATUS_OK;
      end else begin
        evt.status = STATUS_MALFORMED;
      end
      phase_nxt = PH_HEADER;
      pos_nxt   = '0;
      left_nxt  = '0;
      err_nxt   = 1'b0;
    end
  end

  assign push = fire && (evt.has_data || evt.has_status);

  always_comb begin
    schema_nxt = schema_r;
    max_nxt    = max_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SCHEMA_WORD: schema_nxt = cfg_data;
        REG_COUNT_LIMIT: max_nxt    = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      pos_r    <= '0;
      left_r   <= '0;
      err_r    <= 1'b0;
      schema_r <= 32'd1;
      max_r    <= 32'd65535;
    end else begin
      schema_r <= schema_nxt;
      max_r    <= max_nxt;
      if (fire) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        left_r  <= left_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      asm_r <= asm_nxt;
    end
  end

endmodule

@@ design/snaprec_queue.sv @@
// ----------------------------------------------------------------------------
// snaprec_queue
// Short first-in first-out queue of classified words between parser and output.
// ----------------------------------------------------------------------------
module snaprec_queue #(
  parameter int unsigned DEPTH = snaprec_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  snaprec_pkg::snaprec_evt_t push_evt,
  input  logic                      pop,
  output snaprec_pkg::snaprec_evt_t head_evt,
  output logic                      full,
  output logic                      empty
);
  import snaprec_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  snaprec_evt_t  slot_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_FULL);
  assign empty    = (cnt_r == '0);
  assign head_evt = slot_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_evt;
    end
  end

endmodule

@@ design/snaprec_back.sv @@
// ----------------------------------------------------------------------------
// snaprec_back
// Output stage: expands each classified word into one or two result words.
// ----------------------------------------------------------------------------
module snaprec_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  snaprec_pkg::snaprec_evt_t head_evt,
  input  logic                      empty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_result_kind,
  output logic [63:0]               out_tick,
  output logic [31:0]               out_entry_count,
  output logic [63:0]               out_entity_id,
  output logic signed [63:0]        out_entry_value,
  output logic                      out_alive,
  output logic [1:0]                out_status,
  output logic                      out_run_last
);
  import snaprec_pkg::*;

  snaprec_evt_t cur_r, cur_nxt;
  logic         cur_valid_r, cur_valid_nxt;
  logic         out_fire;
  logic         last_fire;
  logic         is_hdr;
  logic         is_ent;

  assign is_hdr = cur_r.has_data && (cur_r.data_kind == KIND_HEADER);
  assign is_ent = cur_r.has_data && (cur_r.data_kind == KIND_ENTRY);

  assign out_valid        = cur_valid_r;
  assign out_result_kind  = cur_r.has_data ? cur_r.data_kind : KIND_STATUS;
  assign out_tick         = is_hdr ? cur_r.word_a : 64'd0;
  assign out_entry_count  = is_hdr ? cur_r.count : 32'd0;
  assign out_entity_id    = is_ent ? cur_r.word_a : 64'd0;
  assign out_entry_value  = is_ent ? $signed(cur_r.word_b) : 64'sd0;
  assign out_alive        = is_ent ? cur_r.alive : 1'b0;
  assign out_status       = cur_r.has_data ? STATUS_OK : cur_r.status;
  assign out_run_last     = !(cur_r.has_data && cur_r.has_status);

  assign out_fire  = cur_valid_r && !out_stall;
  assign last_fire = out_fire && out_run_last;
  // refill when nothing is held or as the last word of the held entry leaves
  assign pop       = !empty && (!cur_valid_r || last_fire);

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    if (pop) begin
      cur_nxt       = head_evt;
      cur_valid_nxt = 1'b1;
    end else if (last_fire) begin
      cur_valid_nxt = 1'b0;
    end else if (out_fire) begin
      // data word taken, status follows
      cur_nxt.has_data = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

@@ bench/snapshot_record_deserializer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// snapshot_record_deserializer_tb
// Self-checking bench: drives snapshot byte buffers (well-formed, truncated,
// corrupted and noise) under several register settings, predicts the header,
// entry and status words in a scoreboard and compares them field by field.
// ----------------------------------------------------------------------------
module snapshot_record_deserializer_tb;
  import snaprec_pkg::*;

  localparam logic [31:0] RESET_SCHEMA = 32'd1;
  localparam logic [31:0] RESET_MAX    = 32'd65535;
  localparam int unsigned PHASE_BYTES  = 220;
  localparam int unsigned NUM_PHASES   = 5;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'd7;

  typedef enum logic [1:0] {
    PHASE_HEADER, PHASE_ENTRIES, PHASE_TRAILING, PHASE_SWALLOW
  } parse_phase_e;

  typedef struct {
    logic [1:0]         kind;
    logic [63:0]        tick;
    logic [31:0]        count;
    logic [63:0]        id;
    logic signed [63:0] value;
    logic               alive;
    logic [1:0]         status;
    logic               run_last;
  } snap_word_t;

  class snapshot_scoreboard;
    logic [31:0]  schema_word;
    logic [31:0]  count_limit;
    parse_phase_e phase;
    int unsigned  pos;
    logic [63:0]  asm_lo;
    logic [63:0]  asm_hi;
    logic [31:0]  entries_left;
    bit           error_seen;
    snap_word_t   expected_words[$];
    int unsigned  failures;

    function new();
      schema_word = RESET_SCHEMA;
      count_limit = RESET_MAX;
      failures = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase = PHASE_HEADER;
      pos = 0;
      asm_lo = '0;
      asm_hi = '0;
      entries_left = '0;
      error_seen = 1'b0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
      if (idx == REG_SCHEMA_WORD) schema_word = data;
      else if (idx == REG_COUNT_LIMIT) count_limit = data;
    endfunction

    function void take_byte(logic [7:0] b);
      if (pos < 8) asm_lo[8*pos +: 8] = b;
      else if (pos < 16) asm_hi[8*(pos-8) +: 8] = b;
    endfunction

    function void parse_error();
      error_seen = 1'b1;
      phase = PHASE_SWALLOW;
    endfunction

    // predicts the words caused by one accepted byte
    function void note_byte(logic [7:0] b, logic eob);
      snap_word_t  w[2];
      int unsigned n;
      logic [31:0] schema;
      logic [31:0] count;
      logic [63:0] tick;
      logic [1:0]  status;
      n = 0;
      case (phase)
        PHASE_HEADER: begin
          take_byte(b);
          if (pos < HEADER_BYTES - 1) begin
            pos++;
          end else begin
            schema = asm_lo[31:0];
            tick = {asm_hi[31:0], asm_lo[63:32]};
            count = asm_hi[63:32];
            pos = 0;
            asm_lo = '0;
            asm_hi = '0;
            if (schema == schema_word && count <= count_limit) begin
              w[n] = '{KIND_HEADER, tick, count, 64'd0, 64'sd0, 1'b0, STATUS_OK, 1'b0};
              n++;
              entries_left = count;
              phase = (count == 0) ? PHASE_TRAILING : PHASE_ENTRIES;
            end else begin
              parse_error();
            end
          end
        end
        PHASE_ENTRIES: begin
          if (pos < ENTRY_BYTES - 1) begin
            take_byte(b);
            pos++;
          end else begin
            if (asm_lo != 0 && b <= 8'd1) begin
              w[n] = '{KIND_ENTRY, 64'd0, 32'd0, asm_lo, asm_hi, b[0], STATUS_OK, 1'b0};
              n++;
              entries_left--;
              if (entries_left == 0) phase = PHASE_TRAILING;
            end else begin
              parse_error();
            end
            pos = 0;
            asm_lo = '0;
            asm_hi = '0;
          end
        end
        PHASE_TRAILING: parse_error();
        default: ;
      endcase
      if (eob) begin
        if (error_seen) status = STATUS_MALFORMED;
        else if (phase == PHASE_HEADER) status = STATUS_SHORT;
        else if (phase == PHASE_TRAILING) status = STATUS_OK;
        else status = STATUS_MALFORMED;
        w[n] = '{KIND_STATUS, 64'd0, 32'd0, 64'd0, 64'sd0, 1'b0, status, 1'b0};
        n++;
        clear_parse();
      end
      for (int unsigned i = 0; i < n; i++) begin
        w[i].run_last = (i == n - 1);
        expected_words.insert(expected_words.size(), w[i]);
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_word(snap_word_t got);
      snap_word_t want;
      if (expected_words.size() == 0) begin
        $error("result word of kind %0d with nothing expected", got.kind);
        failures++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("result_kind", 64'(want.kind), 64'(got.kind));
      compare_field("tick", want.tick, got.tick);
      compare_field("entry_count", 64'(want.count), 64'(got.count));
      compare_field("entity_id", want.id, got.id);
      compare_field("entry_value", want.value, got.value);
      compare_field("alive", 64'(want.alive), 64'(got.alive));
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("run_last", 64'(want.run_last), 64'(got.run_last));
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [7:0]              in_data_byte = 8'd0;
  logic                    in_end_of_buffer = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [1:0]              out_result_kind;
  logic [63:0]             out_tick;
  logic [31:0]             out_entry_count;
  logic [63:0]             out_entity_id;
  logic signed [63:0]      out_entry_value;
  logic                    out_alive;
  logic [1:0]              out_status;
  logic                    out_run_last;

  snapshot_scoreboard board;
  int unsigned        long_hold_cycles = 0;

  snapshot_record_deserializer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_tick         (out_tick),
    .out_entry_count  (out_entry_count),
    .out_entity_id    (out_entity_id),
    .out_entry_value  (out_entry_value),
    .out_alive        (out_alive),
    .out_status       (out_status),
    .out_run_last     (out_run_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---- buffer construction, little-endian
  function automatic void append_le(ref logic [7:0] q[$], input logic [63:0] v,
                                    input int unsigned nbytes);
    for (int unsigned i = 0; i < nbytes; i++) q.insert(q.size(), v[8*i +: 8]);
  endfunction

  function automatic void append_header(ref logic [7:0] q[$], input logic [31:0] schema,
                                        input logic [63:0] tick, input logic [31:0] count);
    append_le(q, 64'(schema), 4);
    append_le(q, tick, 8);
    append_le(q, 64'(count), 4);
  endfunction

  function automatic void append_entry(ref logic [7:0] q[$], input logic [63:0] id,
                                       input logic [63:0] value, input logic [7:0] alive_b);
    append_le(q, id, 8);
    append_le(q, value, 8);
    q.insert(q.size(), alive_b);
  endfunction

  function automatic void build_random_buffer(ref logic [7:0] q[$],
                                              input logic [31:0] schema_cfg,
                                              input logic [31:0] max_cfg,
                                              output bit is_noise);
    int unsigned pick;
    int unsigned n_ent;
    int unsigned bad_at;
    int unsigned keep;
    logic [31:0] schema;
    logic [31:0] count;
    logic [63:0] id;
    logic [63:0] value;
    logic [7:0]  alive_b;
    q.delete();
    is_noise = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick >= 98) begin
      repeat ($urandom_range(1, 30)) q.insert(q.size(), 8'($urandom));
      is_noise = 1'b1;
      return;
    end
    schema = schema_cfg;
    n_ent = $urandom_range(0, (max_cfg < 4) ? max_cfg : 4);
    count = n_ent;
    bad_at = n_ent;
    if (pick >= 74 && pick < 79) begin
      schema = schema_cfg ^ (32'h1 << $urandom_range(0, 31));
    end else if (pick >= 79 && pick < 84) begin
      if (max_cfg == 32'hFFFF_FFFF) begin
        schema = ~schema_cfg;
      end else begin
        count = $urandom;
        if (count <= max_cfg) count = max_cfg + 1;
      end
    end else if (pick >= 84 && pick < 94 && max_cfg != 0) begin
      if (n_ent == 0) begin
        n_ent = 1;
        count = 1;
      end
      bad_at = $urandom_range(0, n_ent - 1);
    end else if (pick >= 94 && n_ent < max_cfg) begin
      count = n_ent + 1;  // announces one entry more than it carries
    end
    append_header(q, schema, {$urandom, $urandom}, count);
    for (int unsigned e = 0; e < n_ent; e++) begin
      id = {$urandom, $urandom};
      if ($urandom_range(0, 7) == 0 || id == 0) id = 64'h1 << $urandom_range(0, 63);
      case ($urandom_range(0, 7))
        0: value = 64'h8000_0000_0000_0000;
        1: value = 64'h7FFF_FFFF_FFFF_FFFF;
        2: value = '1;
        default: value = {$urandom, $urandom};
      endcase
      alive_b = 8'($urandom_range(0, 1));
      if (e == bad_at) begin
        if (pick < 89) id = '0;
        else alive_b = 8'($urandom_range(2, 255));
      end
      append_entry(q, id, value, alive_b);
    end
    if (pick >= 55 && pick < 62) begin
      keep = $urandom_range(1, 15);
      q = q[0:keep-1];
    end else if (pick >= 62 && pick < 68 && q.size() > 17) begin
      keep = $urandom_range(17, q.size() - 1);
      q = q[0:keep-1];
    end else if (pick >= 68 && pick < 74) begin
      repeat ($urandom_range(1, 4)) q.insert(q.size(), 8'($urandom));
    end
  endfunction

  // ---- drivers
  task automatic send_byte(input logic [7:0] b, input logic eob, input bit gaps);
    int unsigned idle;
    idle = gaps ? $urandom_range(0, 9) : 0;
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_buffer <= eob;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_byte(b, eob);
  endtask

  task automatic send_buffer(input logic [7:0] bytes[$], input bit gaps);
    for (int unsigned i = 0; i < bytes.size(); i++)
      send_byte(bytes[i], i == bytes.size() - 1, gaps);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.write_register(idx, data);
  endtask

  task automatic apply_settings(input logic [31:0] schema, input logic [31:0] max_cnt);
    write_register(REG_SCHEMA_WORD, schema);
    write_register(REG_COUNT_LIMIT, max_cnt);
    write_register(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    while (board.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (board.pending() != 0) begin
      $error("%0d result words never arrived", board.pending());
      board.failures++;
      board.expected_words.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic run_directed_cases();
    logic [7:0] q[$];
    q = '{8'hFF};
    send_buffer(q, 1'b0);  // end on the very first byte
    q.delete();
    repeat (15) q.insert(q.size(), 8'h00);
    send_buffer(q, 1'b1);  // end one byte short of a header
    q.delete();
    append_header(q, RESET_SCHEMA, '1, 32'd0);
    send_buffer(q, 1'b0);  // header and ok status from the same byte
    q.delete();
    append_header(q, RESET_SCHEMA, 64'd0, 32'd0);
    q.insert(q.size(), 8'hA5);
    send_buffer(q, 1'b1);  // byte after the last announced entry
    q.delete();
    append_header(q, RESET_SCHEMA + 1, 64'd5, 32'd0);
    send_buffer(q, 1'b0);
    q.delete();
    append_header(q, RESET_SCHEMA, 64'd7, RESET_MAX + 1);
    send_buffer(q, 1'b1);
    q.delete();
    append_header(q, RESET_SCHEMA, 64'h0123_4567_89AB_CDEF, 32'd2);
    append_entry(q, '1, 64'h8000_0000_0000_0000, 8'd1);
    append_entry(q, 64'd1, 64'h7FFF_FFFF_FFFF_FFFF, 8'd0);
    send_buffer(q, 1'b0);
    q.delete();
    append_header(q, RESET_SCHEMA, 64'd1, 32'd1);
    append_entry(q, 64'd0, 64'd3, 8'd1);
    send_buffer(q, 1'b1);  // zero entity
    q.delete();
    append_header(q, RESET_SCHEMA, 64'd1, 32'd1);
    append_entry(q, 64'd9, 64'd3, 8'hFF);
    send_buffer(q, 1'b0);  // bad alive byte
    q.delete();
    append_header(q, RESET_SCHEMA, 64'd2, 32'd2);
    append_entry(q, 64'd4, 64'd4, 8'd1);
    send_buffer(q, 1'b1);  // fewer entries than announced
    q.delete();
    append_header(q, RESET_SCHEMA, 64'd3, 32'd1);
    append_entry(q, 64'd4, 64'd4, 8'd0);
    q = q[0:19];
    send_buffer(q, 1'b0);  // end inside an entry
    q.delete();
    append_header(q, RESET_SCHEMA, 64'd0, RESET_MAX);
    send_buffer(q, 1'b1);
  endtask

  // ---- result sink with random stalls
  initial begin
    int unsigned wait_cycles;
    bit          out_gaps;
    snap_word_t  got;
    out_gaps = 1'b1;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_cycles != 0) begin
        wait_cycles = long_hold_cycles;
        long_hold_cycles = 0;
      end else begin
        wait_cycles = out_gaps ? $urandom_range(0, 9) : 0;
      end
      if ($urandom_range(0, 39) == 0) out_gaps = !out_gaps;
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = '{out_result_kind, out_tick, out_entry_count, out_entity_id, out_entry_value,
              out_alive, out_status, out_run_last};
      board.check_word(got);
    end
  end

  // ---- main sequence
  initial begin
    logic [7:0]  q[$];
    bit          is_noise;
    int unsigned phase_bytes;
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed_cases();
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      in_valid <= 1'b0;
      wait_drained();
      case (p)
        0: begin
          // receiver holds off while a long buffer streams in, filling the block
          long_hold_cycles = 400;
          q.delete();
          append_header(q, board.schema_word, {$urandom, $urandom}, 32'd8);
          repeat (8) append_entry(q, {$urandom, 32'h1}, {$urandom, $urandom}, 8'd1);
          send_buffer(q, 1'b0);
          in_valid <= 1'b0;
          wait_drained();
        end
        1: apply_settings($urandom, $urandom_range(1, 6));
        2: apply_settings(32'd0, 32'd0);
        3: apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: apply_settings($urandom, $urandom_range(2, 5));
      endcase
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        build_random_buffer(q, board.schema_word, board.count_limit, is_noise);
        send_buffer(q, $urandom_range(0, 3) != 0);
        if (!is_noise) phase_bytes += q.size();
      end
    end
    in_valid <= 1'b0;
    wait_drained();
    if (board.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
